// File: hw/rtl/sads_pkg.sv
// ----------------------------------------------------------------------------
// sads_pkg: shared definitions for the two-stack store
// Store geometry, item and status codes, controller states and the RAM
// request bundle.
// ----------------------------------------------------------------------------
package sads_pkg;

	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW     = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_PUSH = 2'd0,
		KIND_POP  = 2'd1,
		KIND_LIST = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_XFER = 1'b1
	} state_t;

	typedef struct packed {
		logic              we;
		logic [AW-1:0]     waddr;
		logic [DATA_W-1:0] wdata;
		logic              re;
		logic [AW-1:0]     raddr;
	} ram_req_t;

endpackage

// File: hw/rtl/sads_if.sv
// ----------------------------------------------------------------------------
// sads_if: handshake channels of the two-stack store
// Request channel carries one command word, response channel one result word.
// ----------------------------------------------------------------------------
interface sads_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic               which_end;
	logic signed [31:0] push_value;

	modport source (output valid, output kind, output which_end, output push_value,
		input ready);
	modport sink (input valid, input kind, input which_end, input push_value,
		output ready);
endinterface

interface sads_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] data_value;
	logic [1:0]         status;
	logic               from_high;
	logic               last;

	modport source (output valid, output data_value, output status, output from_high,
		output last, input ready);
	modport sink (input valid, input data_value, input status, input from_high,
		input last, output ready);
endinterface

// File: hw/rtl/shared_array_double_stack.sv
// ----------------------------------------------------------------------------
// shared_array_double_stack: two stacks in one word store
// Top level joining the command sequencer and the shared store.
// ----------------------------------------------------------------------------
// Two stacks share one store of DEPTH 32-bit words: the low stack grows up from
// entry 0 and the high stack grows down from the last entry. One command word is
// taken at a time. A push, a failed pop and a listing of empty stacks finish in
// the cycle they are accepted, so a new command can follow in the next cycle. A
// successful pop passes through the transfer state, because the store's read
// data is registered. A listing reads its words through the store port one word
// per cycle while the response side keeps up. A result word that the response
// side has not yet taken holds off the next command, and such back-pressure
// also stalls the command in hand.
// ----------------------------------------------------------------------------
module shared_array_double_stack (
	input  logic        clk,
	input  logic        arst_n,
	sads_req_if.sink    req,
	sads_rsp_if.source  rsp
);

	sads_pkg::ram_req_t          ram_req;
	logic [sads_pkg::DATA_W-1:0] ram_rdata;

	sads_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	sads_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

endmodule

// File: hw/rtl/sads_ram.sv
// ----------------------------------------------------------------------------
// sads_ram: word store shared by both stacks
// One write port and one read port; read data is registered and held until
// the next read.
// ----------------------------------------------------------------------------
module sads_ram (
	input  logic                          clk,
	input  sads_pkg::ram_req_t            req,
	output logic [sads_pkg::DATA_W-1:0]   rdata
);

	logic [sads_pkg::DATA_W-1:0] mem [sads_pkg::DEPTH];
	logic [sads_pkg::DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/sads_ctrl.sv
// ----------------------------------------------------------------------------
// sads_ctrl: command sequencer for the two-stack store
// Keeps both stack counts, drives the store and fills the result register.
// ----------------------------------------------------------------------------
module sads_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	sads_req_if.sink                      req,
	sads_rsp_if.source                    rsp,
	output sads_pkg::ram_req_t            ram_req,
	input  logic [sads_pkg::DATA_W-1:0]   ram_rdata
);

	localparam int AW = sads_pkg::AW;
	localparam int CW = sads_pkg::CW;

	sads_pkg::state_t state_q, state_d;
	logic [CW-1:0] low_count_q, low_count_d;
	logic [CW-1:0] high_count_q, high_count_d;
	logic [AW-1:0] addr_q, addr_d;
	logic [CW-1:0] rem_q, rem_d;
	logic          phase_high_q, phase_high_d;

	logic                        rsp_valid_q;
	logic [sads_pkg::DATA_W-1:0] rsp_data_q;
	logic [1:0]                  rsp_status_q;
	logic                        rsp_high_q;
	logic                        rsp_last_q;

	logic                        slot_free;
	logic                        in_ready;
	logic                        acc;
	logic                        is_high;
	logic [CW-1:0]               total;
	logic                        start_xfer;
	logic                        xfer_done;
	logic                        load;
	logic [sads_pkg::DATA_W-1:0] ld_data;
	sads_pkg::status_t           ld_status;
	logic                        ld_high;
	logic                        ld_last;
	logic [AW-1:0]               nxt_addr;

	assign slot_free = !rsp_valid_q || rsp.ready;
	assign in_ready  = (state_q == sads_pkg::S_IDLE) && slot_free;
	assign req.ready = in_ready;
	assign acc       = req.valid && in_ready;
	assign is_high   = !req.which_end;
	assign total     = low_count_q + high_count_q;

	// Walk order: high stack upwards to the end of the store, then low stack downwards.
	always_comb begin
		if (phase_high_q && addr_q == AW'(sads_pkg::DEPTH - 1)) begin
			nxt_addr = AW'(low_count_q - CW'(1));
		end else if (phase_high_q) begin
			nxt_addr = addr_q + AW'(1);
		end else begin
			nxt_addr = addr_q - AW'(1);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			sads_pkg::S_IDLE: begin
				if (start_xfer) begin
					state_d = sads_pkg::S_XFER;
				end
			end
			sads_pkg::S_XFER: begin
				if (xfer_done) begin
					state_d = sads_pkg::S_IDLE;
				end
			end
			default: state_d = sads_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ram_req      = '0;
		load         = 1'b0;
		ld_data      = '0;
		ld_status    = sads_pkg::ST_OK;
		ld_high      = 1'b0;
		ld_last      = 1'b1;
		low_count_d  = low_count_q;
		high_count_d = high_count_q;
		addr_d       = addr_q;
		rem_d        = rem_q;
		phase_high_d = phase_high_q;
		start_xfer   = 1'b0;
		xfer_done    = 1'b0;
		case (state_q)
			sads_pkg::S_IDLE: begin
				if (acc) begin
					case (req.kind)
						sads_pkg::KIND_PUSH: begin
							load    = 1'b1;
							ld_high = is_high;
							if (total >= CW'(sads_pkg::DEPTH)) begin
								ld_status = sads_pkg::ST_OVERFLOW;
							end else begin
								ram_req.we    = 1'b1;
								ram_req.wdata = req.push_value;
								if (is_high) begin
									ram_req.waddr = AW'(CW'(sads_pkg::DEPTH - 1) - high_count_q);
									high_count_d  = high_count_q + CW'(1);
								end else begin
									ram_req.waddr = AW'(low_count_q);
									low_count_d   = low_count_q + CW'(1);
								end
							end
						end
						sads_pkg::KIND_POP: begin
							if (is_high && high_count_q == '0) begin
								load      = 1'b1;
								ld_high   = 1'b1;
								ld_status = sads_pkg::ST_UNDERFLOW;
							end else if (!is_high && low_count_q == '0) begin
								load      = 1'b1;
								ld_status = sads_pkg::ST_UNDERFLOW;
							end else begin
								start_xfer   = 1'b1;
								ram_req.re   = 1'b1;
								rem_d        = CW'(1);
								phase_high_d = is_high;
								if (is_high) begin
									ram_req.raddr = AW'(CW'(sads_pkg::DEPTH) - high_count_q);
									high_count_d  = high_count_q - CW'(1);
								end else begin
									ram_req.raddr = AW'(low_count_q - CW'(1));
									low_count_d   = low_count_q - CW'(1);
								end
								addr_d = ram_req.raddr;
							end
						end
						sads_pkg::KIND_LIST: begin
							if (total == '0) begin
								load      = 1'b1;
								ld_status = sads_pkg::ST_EMPTY;
							end else begin
								start_xfer   = 1'b1;
								ram_req.re   = 1'b1;
								rem_d        = total;
								phase_high_d = (high_count_q != '0);
								if (high_count_q != '0) begin
									ram_req.raddr = AW'(CW'(sads_pkg::DEPTH) - high_count_q);
								end else begin
									ram_req.raddr = AW'(low_count_q - CW'(1));
								end
								addr_d = ram_req.raddr;
							end
						end
						default: ;
					endcase
				end
			end
			sads_pkg::S_XFER: begin
				// The store holds its last read word until the next read is issued.
				if (slot_free) begin
					load    = 1'b1;
					ld_data = ram_rdata;
					ld_high = phase_high_q;
					ld_last = (rem_q == CW'(1));
					if (rem_q == CW'(1)) begin
						xfer_done = 1'b1;
					end else begin
						ram_req.re    = 1'b1;
						ram_req.raddr = nxt_addr;
						addr_d        = nxt_addr;
						rem_d         = rem_q - CW'(1);
						if (phase_high_q && addr_q == AW'(sads_pkg::DEPTH - 1)) begin
							phase_high_d = 1'b0;
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= sads_pkg::S_IDLE;
			low_count_q  <= '0;
			high_count_q <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			low_count_q  <= low_count_d;
			high_count_q <= high_count_d;
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_q       <= addr_d;
		rem_q        <= rem_d;
		phase_high_q <= phase_high_d;
		if (load) begin
			rsp_data_q   <= ld_data;
			rsp_status_q <= ld_status;
			rsp_high_q   <= ld_high;
			rsp_last_q   <= ld_last;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.data_value = rsp_data_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.from_high  = rsp_high_q;
	assign rsp.last       = rsp_last_q;

	a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_req.we && ram_req.re))
		else $error("store written and read in the same cycle");

	a_counts_fit: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, low_count_q} + {1'b0, high_count_q}) <= (CW + 1)'(sads_pkg::DEPTH))
		else $error("stack counts exceed the store");

	a_xfer_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sads_pkg::S_XFER |-> rem_q != '0)
		else $error("transfer running with nothing left to send");

	a_counts_move_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		!acc |=> $stable(low_count_q) && $stable(high_count_q))
		else $error("stack count changed without an accepted word");

	a_no_write_in_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sads_pkg::S_XFER |-> !ram_req.we)
		else $error("store written during a read-out");

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the two-stack shared store
// Drives push, pop, listing and unused command kinds with random gaps on both channels,
// predicts every result word from a shadow copy of both stacks and checks
// each returned word field by field in order.
// ----------------------------------------------------------------------------
module testbench;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic       END_HIGH    = 1'b0;
	localparam logic       END_LOW     = 1'b1;
	localparam int         RANDOM_CMDS = 90;
	localparam int         IDLE_LIMIT  = 3000;
	localparam int         DRAIN_WAIT  = 40;
	localparam int         HOLD_AT     = 45;
	localparam int         HOLD_LEN    = 90;

	typedef struct {
		logic [1:0]  kind;
		logic        which_end;
		logic [31:0] value;
	} stack_cmd_t;

	typedef struct {
		logic [31:0]       data;
		sads_pkg::status_t status;
		logic              from_high;
		logic              last;
	} stack_word_t;

	logic clk;
	logic arst_n;

	sads_req_if req_ch ();
	sads_rsp_if rsp_ch ();

	shared_array_double_stack dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	stack_cmd_t  cmd_queue[$];
	stack_word_t expected_words[$];

	// Shadow copy of the shared store and the two stack heights.
	logic [31:0] shadow_store [sads_pkg::DEPTH];
	int          low_height;
	int          high_height;

	int errors;
	int cmds_taken;
	int words_seen;
	int n_push, n_pop, n_list, n_overflow, n_underflow, n_empty, longest_list;
	int idle_cycles;
	int send_gap, send_calm, take_gap, take_calm, hold_left;
	bit hold_done;
	logic on_hold;
	stack_cmd_t next_cmd;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(10, 30);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 20);
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	task automatic add_cmd(input logic [1:0] kind, input logic which_end,
		input logic [31:0] value);
		stack_cmd_t c;
		c.kind      = kind;
		c.which_end = which_end;
		c.value     = value;
		cmd_queue.push_back(c);
	endtask

	task automatic expect_word(input logic [31:0] data, input sads_pkg::status_t status,
		input logic from_high, input logic last);
		stack_word_t w;
		w.data      = data;
		w.status    = status;
		w.from_high = from_high;
		w.last      = last;
		expected_words.push_back(w);
	endtask

	// Works out the result words of one accepted command and updates the shadow.
	task automatic predict_results(input logic [1:0] kind, input logic which_end,
		input logic [31:0] value);
		logic to_high;
		int   total;
		int   k;
		to_high = (which_end == END_HIGH);
		total   = low_height + high_height;
		case (kind)
			sads_pkg::KIND_PUSH: begin
				n_push++;
				if (total >= sads_pkg::DEPTH) begin
					n_overflow++;
					expect_word('0, sads_pkg::ST_OVERFLOW, to_high, 1'b1);
				end else begin
					if (to_high) begin
						high_height++;
						shadow_store[sads_pkg::DEPTH - high_height] = value;
					end else begin
						shadow_store[low_height] = value;
						low_height++;
					end
					expect_word('0, sads_pkg::ST_OK, to_high, 1'b1);
				end
			end
			sads_pkg::KIND_POP: begin
				n_pop++;
				if (to_high) begin
					if (high_height == 0) begin
						n_underflow++;
						expect_word('0, sads_pkg::ST_UNDERFLOW, 1'b1, 1'b1);
					end else begin
						expect_word(shadow_store[sads_pkg::DEPTH - high_height],
							sads_pkg::ST_OK, 1'b1, 1'b1);
						high_height--;
					end
				end else begin
					if (low_height == 0) begin
						n_underflow++;
						expect_word('0, sads_pkg::ST_UNDERFLOW, 1'b0, 1'b1);
					end else begin
						low_height--;
						expect_word(shadow_store[low_height], sads_pkg::ST_OK, 1'b0, 1'b1);
					end
				end
			end
			sads_pkg::KIND_LIST: begin
				n_list++;
				if (total == 0) begin
					n_empty++;
					expect_word('0, sads_pkg::ST_EMPTY, 1'b0, 1'b1);
				end else begin
					if (total > longest_list)
						longest_list = total;
					k = 0;
					for (int i = sads_pkg::DEPTH - high_height; i < sads_pkg::DEPTH; i++) begin
						k++;
						expect_word(shadow_store[i], sads_pkg::ST_OK, 1'b1, k == total);
					end
					for (int i = low_height - 1; i >= 0; i--) begin
						k++;
						expect_word(shadow_store[i], sads_pkg::ST_OK, 1'b0, k == total);
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic flag_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		errors++;
		$display("MISMATCH at result word %0d, %s: got %h, expected %h",
			words_seen, what, got, want);
	endtask

	task automatic check_result();
		stack_word_t want;
		words_seen++;
		if (expected_words.size() == 0) begin
			flag_mismatch("word with nothing outstanding", rsp_ch.data_value, '0);
			return;
		end
		want = expected_words.pop_front();
		if (rsp_ch.data_value !== want.data)
			flag_mismatch("data_value", rsp_ch.data_value, want.data);
		if (rsp_ch.status !== want.status)
			flag_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
		if (rsp_ch.from_high !== want.from_high)
			flag_mismatch("from_high", 32'(rsp_ch.from_high), 32'(want.from_high));
		if (rsp_ch.last !== want.last)
			flag_mismatch("last", 32'(rsp_ch.last), 32'(want.last));
	endtask

	// Command sender.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid      <= 1'b0;
			req_ch.kind       <= sads_pkg::KIND_PUSH;
			req_ch.which_end  <= END_HIGH;
			req_ch.push_value <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				cmds_taken++;
				predict_results(req_ch.kind, req_ch.which_end, req_ch.push_value);
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					req_ch.valid <= 1'b0;
				end else if (cmd_queue.size() > 0) begin
					next_cmd = cmd_queue.pop_front();
					req_ch.valid      <= 1'b1;
					req_ch.kind       <= next_cmd.kind;
					req_ch.which_end  <= next_cmd.which_end;
					req_ch.push_value <= next_cmd.value;
					// Keep offering words while the receiver is held off.
					send_gap = on_hold ? 0 : pick_gap(send_calm);
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result receiver, with one long hold-off so that the block backs up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			on_hold      <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				check_result();
				take_gap = pick_gap(take_calm);
			end
			if (!hold_done && cmds_taken >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
				on_hold      <= 1'b1;
			end else if (take_gap > 0) begin
				take_gap--;
				rsp_ch.ready <= 1'b0;
				on_hold      <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
				on_hold      <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout: no word moved for %0d cycles, %0d results outstanding",
				IDLE_LIMIT, expected_words.size());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int   counted;
		int   mode;
		int   r;
		logic side;

		req_ch.valid      = 1'b0;
		req_ch.kind       = sads_pkg::KIND_PUSH;
		req_ch.which_end  = END_HIGH;
		req_ch.push_value = '0;
		rsp_ch.ready      = 1'b0;
		arst_n            = 1'b0;

		// Empty store: listing, and pops from both ends; then pushes, a listing, pops and an unused kind.
		add_cmd(sads_pkg::KIND_LIST, END_HIGH, '0);
		add_cmd(sads_pkg::KIND_POP, END_HIGH, '0);
		add_cmd(sads_pkg::KIND_POP, END_LOW, '0);
		add_cmd(sads_pkg::KIND_PUSH, END_HIGH, 32'h7fff_ffff);
		add_cmd(sads_pkg::KIND_PUSH, END_LOW, 32'h8000_0000);
		add_cmd(sads_pkg::KIND_PUSH, END_HIGH, 32'hffff_ffff);
		add_cmd(sads_pkg::KIND_PUSH, END_LOW, 32'h0000_0000);
		add_cmd(sads_pkg::KIND_LIST, END_LOW, 32'hffff_ffff);
		add_cmd(sads_pkg::KIND_POP, END_HIGH, 32'hffff_ffff);
		add_cmd(sads_pkg::KIND_POP, END_LOW, '0);
		add_cmd(KIND_UNUSED, END_LOW, 32'h5a5a_5a5a);
		// Fill the store until the stacks meet, then push into a full store.
		for (int i = 0; i < sads_pkg::DEPTH - 2; i++)
			add_cmd(sads_pkg::KIND_PUSH, logic'($urandom_range(0, 1)), pick_value());
		add_cmd(sads_pkg::KIND_PUSH, END_HIGH, 32'h1234_5678);
		add_cmd(sads_pkg::KIND_PUSH, END_LOW, 32'h8765_4321);
		add_cmd(sads_pkg::KIND_LIST, END_HIGH, '0);

		// Random part in blocks that lean towards filling, draining or a mix.
		counted = 0;
		mode    = 1;
		while (counted < RANDOM_CMDS) begin
			if (counted % 20 == 0)
				mode = $urandom_range(0, 2);
			r    = $urandom_range(0, 99);
			side = logic'($urandom_range(0, 1));
			if (r < 3) begin
				add_cmd(KIND_UNUSED, side, $urandom);
				continue;
			end
			if (r < 11)
				add_cmd(sads_pkg::KIND_LIST, side, $urandom);
			else if ((mode == 0 && r < 80) || (mode == 1 && r < 30) || (mode == 2 && r < 55))
				add_cmd(sads_pkg::KIND_PUSH, side, pick_value());
			else
				add_cmd(sads_pkg::KIND_POP, side, $urandom);
			counted++;
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (cmd_queue.size() > 0 || req_ch.valid || expected_words.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Ran %0d commands (%0d pushes, %0d pops, %0d listings), %0d result words",
			cmds_taken, n_push, n_pop, n_list, words_seen);
		$display("Saw %0d overflows, %0d underflows, %0d empty listings, longest listing %0d",
			n_overflow, n_underflow, n_empty, longest_list);
		if (errors == 0 && expected_words.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// File: shared_array_double_stack.f
hw/rtl/sads_pkg.sv
hw/rtl/sads_if.sv
hw/rtl/sads_ram.sv
hw/rtl/sads_ctrl.sv
hw/rtl/shared_array_double_stack.sv
tb/testbench.sv
